/* rtl/core/lnkt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lnkt_pkg: shared types and constants of the keyboard tone generator
// Item and result layouts, default sizes and the half period table.
// ----------------------------------------------------------------------------
package lnkt_pkg;

  localparam int NUM_KEYS_DEF     = 25;
  localparam int STACK_DEPTH_DEF  = 32;
  localparam int NUM_OCTAVES_DEF  = 5;
  localparam int PERIOD_WIDTH_DEF = 16;

  localparam int KEY_FIELD_W = 25;
  localparam int KEY_W       = 5;
  localparam int HP_FIELD_W  = 16;
  localparam int OCT_W       = 3;
  localparam int TDATA_W     = 32;

  localparam int TBL_ROWS   = 5;
  localparam int TBL_COLS   = 13;
  localparam int TBL_ROW_W  = 3;
  localparam int TBL_COL_W  = 4;
  localparam int TBL_VAL_W  = 16;
  localparam int KEY_MAX    = 24;
  localparam int COL_SPLIT  = 12;

  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [KEY_FIELD_W-1:0] keys;
    logic                   octave_down;
    logic                   octave_up;
    logic                   scan;
  } lnkt_item_t;

  // first member lands in the top bits: speaker_level ends up at bit 0
  typedef struct packed {
    logic                  push_dropped;
    logic [OCT_W-1:0]      octave_now;
    logic [HP_FIELD_W-1:0] half_period_ticks;
    logic [KEY_W-1:0]      sounding_key;
    logic                  tone_active;
    logic                  speaker_level;
  } lnkt_result_t;

  localparam int IN_PAD_W  = TDATA_W - KEY_FIELD_W - 2;
  localparam int OUT_PAD_W = TDATA_W - $bits(lnkt_result_t);

  localparam logic [TBL_VAL_W-1:0] HALF_TABLE [TBL_ROWS][TBL_COLS] = '{
    '{16'd15288, 16'd14430, 16'd13620, 16'd12857, 16'd12134, 16'd11453, 16'd10811,
      16'd10204, 16'd9631, 16'd9091, 16'd8581, 16'd8099, 16'd7645},
    '{16'd7645, 16'd7215, 16'd6811, 16'd6428, 16'd6068, 16'd5727, 16'd5405,
      16'd5102, 16'd4816, 16'd4545, 16'd4290, 16'd4049, 16'd3822},
    '{16'd3822, 16'd3608, 16'd3405, 16'd3214, 16'd3034, 16'd2863, 16'd2703,
      16'd2551, 16'd2408, 16'd2272, 16'd2145, 16'd2025, 16'd1911},
    '{16'd1911, 16'd1804, 16'd1703, 16'd1607, 16'd1517, 16'd1432, 16'd1351,
      16'd1275, 16'd1204, 16'd1136, 16'd1073, 16'd1012, 16'd955},
    '{16'd955, 16'd902, 16'd851, 16'd803, 16'd758, 16'd716, 16'd676,
      16'd638, 16'd602, 16'd568, 16'd536, 16'd506, 16'd477}
  };

endpackage

/* rtl/core/last_note_keyboard_tone_generator_unit.sv */
`timescale 1ns / 1ps
// A scan tick first walks the keys; every tick then pops released keys off the stack top,
// picks the half period and steps the wave into the result register.
// The back end takes one tick at a time, a new one only from its idle state; the key walk
// goes one key per cycle and the pop loop reads the stack top and then checks it per pop.
// A two-entry queue and the result register let intake and output stall on their own.
// Reset: stack empty, key flags clear, octave 2, wave low; stack memory is not cleared.
// ----------------------------------------------------------------------------
// last_note_keyboard_tone_generator_unit: last-note keyboard square tone
// Top level: packs the stream ports, queue front end and stack back end.
// ----------------------------------------------------------------------------
module last_note_keyboard_tone_generator_unit #(
  parameter int NUM_KEYS     = lnkt_pkg::NUM_KEYS_DEF,
  parameter int STACK_DEPTH  = lnkt_pkg::STACK_DEPTH_DEF,
  parameter int NUM_OCTAVES  = lnkt_pkg::NUM_OCTAVES_DEF,
  parameter int PERIOD_WIDTH = lnkt_pkg::PERIOD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // [24:0] key_pressed, [25] octave_down, [26] octave_up, [31:27] zero
  input  logic [lnkt_pkg::TDATA_W-1:0]  in_tdata,
  // [0] scan_strobe
  input  logic                          in_tuser,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // [0] speaker_level, [1] tone_active, [6:2] sounding_key,
  // [22:7] half_period_ticks, [25:23] octave_now, [26] push_dropped, [31:27] zero
  output logic [lnkt_pkg::TDATA_W-1:0]  out_tdata
);

  lnkt_pkg::lnkt_item_t   in_item;
  lnkt_pkg::lnkt_item_t   q_item;
  logic                   q_valid, q_ready;
  lnkt_pkg::lnkt_result_t res_data;

  always_comb begin
    in_item.keys        = in_tdata[lnkt_pkg::KEY_FIELD_W-1:0];
    in_item.octave_down = in_tdata[lnkt_pkg::KEY_FIELD_W];
    in_item.octave_up   = in_tdata[lnkt_pkg::KEY_FIELD_W+1];
    in_item.scan        = in_tuser;
  end

  lnkt_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_item  (in_item),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_item   (q_item)
  );

  lnkt_back #(
    .NUM_KEYS     (NUM_KEYS),
    .STACK_DEPTH  (STACK_DEPTH),
    .NUM_OCTAVES  (NUM_OCTAVES),
    .PERIOD_WIDTH (PERIOD_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_item    (q_item),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res_data  (res_data)
  );

  assign out_tdata = {{lnkt_pkg::OUT_PAD_W{1'b0}}, res_data};

endmodule

/* rtl/core/lnkt_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lnkt_front: tick intake and request queue
// Accepts ticks, drops octave buttons on ticks without a scan, and holds
// them in a short queue for the back end.
// ----------------------------------------------------------------------------
module lnkt_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  lnkt_pkg::lnkt_item_t in_item,
  output logic                q_valid,
  input  logic                q_ready,
  output lnkt_pkg::lnkt_item_t q_item
);

  localparam int PTR_W = $clog2(lnkt_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(lnkt_pkg::QUEUE_DEPTH + 1);

  lnkt_pkg::lnkt_item_t q_mem_r [lnkt_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             push, pop;
  lnkt_pkg::lnkt_item_t item_cls;

  assign in_ready = (cnt_r != CNT_W'(lnkt_pkg::QUEUE_DEPTH));
  assign q_valid  = (cnt_r != '0);
  assign q_item   = q_mem_r[rd_ptr_r];
  assign push     = in_valid & in_ready;
  assign pop      = q_valid & q_ready;

  always_comb begin
    item_cls             = in_item;
    // octave buttons count only on scan ticks
    item_cls.octave_down = in_item.octave_down & in_item.scan;
    item_cls.octave_up   = in_item.octave_up & in_item.scan;
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(lnkt_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(lnkt_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= item_cls;
    end
  end

endmodule

/* rtl/core/lnkt_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lnkt_back: key stack sequencer and square wave generator
// Walks scan keys one per cycle, pops released keys (stack read, then check),
// picks the half period and steps the wave into the result register.
// ----------------------------------------------------------------------------
module lnkt_back #(
  parameter int NUM_KEYS     = lnkt_pkg::NUM_KEYS_DEF,
  parameter int STACK_DEPTH  = lnkt_pkg::STACK_DEPTH_DEF,
  parameter int NUM_OCTAVES  = lnkt_pkg::NUM_OCTAVES_DEF,
  parameter int PERIOD_WIDTH = lnkt_pkg::PERIOD_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  output logic                  q_ready,
  input  lnkt_pkg::lnkt_item_t  q_item,
  output logic                  res_valid,
  input  logic                  res_ready,
  output lnkt_pkg::lnkt_result_t res_data
);

  localparam int KIDX_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam int ADDR_W = $clog2(STACK_DEPTH);
  localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
  localparam int CMP_W  = (PERIOD_WIDTH > lnkt_pkg::TBL_VAL_W) ? PERIOD_WIDTH
                                                               : lnkt_pkg::TBL_VAL_W;
  localparam logic [CMP_W-1:0] HP_MAX = CMP_W'((64'd1 << PERIOD_WIDTH) - 64'd1);
  localparam logic [lnkt_pkg::OCT_W-1:0] OCT_RST  = lnkt_pkg::OCT_W'(2 % NUM_OCTAVES);
  localparam logic [lnkt_pkg::OCT_W-1:0] OCT_LAST = lnkt_pkg::OCT_W'(NUM_OCTAVES - 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_RDTOP = 3'd2;
  localparam logic [2:0] S_CHK   = 3'd3;
  localparam logic [2:0] S_HP    = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0]                    state_r, state_nxt;
  logic [KIDX_W-1:0]             kidx_r, kidx_nxt;
  logic [NUM_KEYS-1:0]           wkeys_r, wkeys_nxt;
  logic                          wdn_r, wdn_nxt;
  logic                          wup_r, wup_nxt;
  logic [NUM_KEYS-1:0]           flags_r, flags_nxt;
  logic [CNT_W-1:0]              count_r, count_nxt;
  logic [lnkt_pkg::OCT_W-1:0]    oct_r, oct_nxt;
  logic [PERIOD_WIDTH-1:0]       wave_cnt_r, wave_cnt_nxt;
  logic                          wave_lvl_r, wave_lvl_nxt;
  logic                          drop_r, drop_nxt;
  logic [lnkt_pkg::KEY_W-1:0]    top_r, top_nxt;
  logic [PERIOD_WIDTH-1:0]       hp_r, hp_nxt;
  logic                          out_valid_r, out_valid_nxt;
  lnkt_pkg::lnkt_result_t        out_data_r, out_data_nxt;

  logic [lnkt_pkg::KEY_W-1:0]    stack_mem [STACK_DEPTH];
  logic [lnkt_pkg::KEY_W-1:0]    rd_data_r;
  logic                          mem_we, mem_re;
  logic [ADDR_W-1:0]             mem_waddr, mem_raddr;
  logic [lnkt_pkg::KEY_W-1:0]    mem_wdata;

  logic [lnkt_pkg::OCT_W-1:0]    oct_dn, oct_up;
  logic                          top_pressed;
  logic                          active;
  logic                          out_free;
  logic [lnkt_pkg::KEY_W-1:0]    col_clamp;
  logic [lnkt_pkg::TBL_COL_W-1:0] col;
  logic [lnkt_pkg::TBL_ROW_W-1:0] row;
  logic [lnkt_pkg::TBL_VAL_W-1:0] tbl_val;
  logic [CMP_W-1:0]              tbl_ext;
  logic [PERIOD_WIDTH-1:0]       hp_pick;
  logic [PERIOD_WIDTH-1:0]       wave_lim;
  logic [PERIOD_WIDTH:0]         wave_inc;

  assign active   = (count_r != '0);
  assign out_free = ~out_valid_r | res_ready;

  // octave buttons: down first, then up
  always_comb begin
    oct_dn = oct_r;
    if (wdn_r) begin
      oct_dn = (oct_r == '0) ? OCT_LAST : oct_r - 1'b1;
    end
    oct_up = oct_dn;
    if (wup_r) begin
      oct_up = (oct_dn >= OCT_LAST) ? '0 : oct_dn + 1'b1;
    end
  end

  always_comb begin
    top_pressed = 1'b0;
    for (int j = 0; j < NUM_KEYS; j++) begin
      if (rd_data_r == lnkt_pkg::KEY_W'(j)) begin
        top_pressed = wkeys_r[j];
      end
    end
  end

  // table lookup: upper keys move to the next row, a row past the table is
  // the last row halved
  always_comb begin
    col_clamp = (top_r > lnkt_pkg::KEY_W'(lnkt_pkg::KEY_MAX))
                ? lnkt_pkg::KEY_W'(lnkt_pkg::KEY_MAX) : top_r;
    if (col_clamp > lnkt_pkg::KEY_W'(lnkt_pkg::COL_SPLIT)) begin
      col = lnkt_pkg::TBL_COL_W'(col_clamp - lnkt_pkg::KEY_W'(lnkt_pkg::COL_SPLIT));
      row = lnkt_pkg::TBL_ROW_W'(oct_r) + 1'b1;
    end else begin
      col = lnkt_pkg::TBL_COL_W'(col_clamp);
      row = lnkt_pkg::TBL_ROW_W'(oct_r);
    end
    if (row >= lnkt_pkg::TBL_ROW_W'(lnkt_pkg::TBL_ROWS)) begin
      tbl_val = lnkt_pkg::HALF_TABLE[lnkt_pkg::TBL_ROW_W'(lnkt_pkg::TBL_ROWS - 1)][col] >> 1;
    end else begin
      tbl_val = lnkt_pkg::HALF_TABLE[row][col];
    end
    tbl_ext = CMP_W'(tbl_val);
    hp_pick = (tbl_ext > HP_MAX) ? HP_MAX[PERIOD_WIDTH-1:0] : tbl_ext[PERIOD_WIDTH-1:0];
  end

  always_comb begin
    wave_lim = (hp_r == '0) ? PERIOD_WIDTH'(1) : hp_r;
    wave_inc = {1'b0, wave_cnt_r} + 1'b1;
  end

  always_comb begin
    state_nxt     = state_r;
    kidx_nxt      = kidx_r;
    wkeys_nxt     = wkeys_r;
    wdn_nxt       = wdn_r;
    wup_nxt       = wup_r;
    flags_nxt     = flags_r;
    count_nxt     = count_r;
    oct_nxt       = oct_r;
    wave_cnt_nxt  = wave_cnt_r;
    wave_lvl_nxt  = wave_lvl_r;
    drop_nxt      = drop_r;
    top_nxt       = top_r;
    hp_nxt        = hp_r;
    out_valid_nxt = out_valid_r & ~res_ready;
    out_data_nxt  = out_data_r;
    q_ready       = 1'b0;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_waddr     = count_r[ADDR_W-1:0];
    mem_raddr     = ADDR_W'(count_r - 1'b1);
    mem_wdata     = lnkt_pkg::KEY_W'(kidx_r);

    unique case (state_r)
      S_IDLE: begin
        q_ready = 1'b1;
        if (q_valid) begin
          wkeys_nxt = q_item.keys[NUM_KEYS-1:0];
          wdn_nxt   = q_item.octave_down;
          wup_nxt   = q_item.octave_up;
          drop_nxt  = 1'b0;
          kidx_nxt  = '0;
          state_nxt = q_item.scan ? S_SCAN : S_RDTOP;
        end
      end
      S_SCAN: begin
        if (wkeys_r[kidx_r]) begin
          if (!flags_r[kidx_r]) begin
            if (count_r < CNT_W'(STACK_DEPTH)) begin
              mem_we            = 1'b1;
              count_nxt         = count_r + 1'b1;
              flags_nxt[kidx_r] = 1'b1;
            end else begin
              // stack full: drop, flag stays clear so the press retries
              drop_nxt = 1'b1;
            end
          end
        end else begin
          flags_nxt[kidx_r] = 1'b0;
        end
        if (kidx_r == KIDX_W'(NUM_KEYS - 1)) begin
          oct_nxt   = oct_up;
          state_nxt = S_RDTOP;
        end else begin
          kidx_nxt = kidx_r + 1'b1;
        end
      end
      S_RDTOP: begin
        if (active) begin
          mem_re    = 1'b1;
          state_nxt = S_CHK;
        end else begin
          top_nxt   = '0;
          state_nxt = S_HP;
        end
      end
      S_CHK: begin
        if (top_pressed) begin
          top_nxt   = rd_data_r;
          state_nxt = S_HP;
        end else begin
          // pop the released top key
          count_nxt = count_r - 1'b1;
          for (int j = 0; j < NUM_KEYS; j++) begin
            if (rd_data_r == lnkt_pkg::KEY_W'(j)) begin
              flags_nxt[j] = 1'b0;
            end
          end
          state_nxt = S_RDTOP;
        end
      end
      S_HP: begin
        hp_nxt    = active ? hp_pick : '0;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          if (active) begin
            if (wave_inc >= {1'b0, wave_lim}) begin
              wave_cnt_nxt = '0;
              wave_lvl_nxt = ~wave_lvl_r;
            end else begin
              wave_cnt_nxt = wave_inc[PERIOD_WIDTH-1:0];
            end
          end else begin
            wave_cnt_nxt = '0;
          end
          out_data_nxt.speaker_level     = active ? (wave_inc >= {1'b0, wave_lim}) ^ wave_lvl_r
                                                  : wave_lvl_r;
          out_data_nxt.tone_active       = active;
          out_data_nxt.sounding_key      = top_r;
          out_data_nxt.half_period_ticks = lnkt_pkg::HP_FIELD_W'(hp_r);
          out_data_nxt.octave_now        = oct_r;
          out_data_nxt.push_dropped      = drop_r;
          out_valid_nxt                  = 1'b1;
          state_nxt                      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      flags_r     <= '0;
      count_r     <= '0;
      oct_r       <= OCT_RST;
      wave_cnt_r  <= '0;
      wave_lvl_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      flags_r     <= flags_nxt;
      count_r     <= count_nxt;
      oct_r       <= oct_nxt;
      wave_cnt_r  <= wave_cnt_nxt;
      wave_lvl_r  <= wave_lvl_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kidx_r     <= kidx_nxt;
    wkeys_r    <= wkeys_nxt;
    wdn_r      <= wdn_nxt;
    wup_r      <= wup_nxt;
    drop_r     <= drop_nxt;
    top_r      <= top_nxt;
    hp_r       <= hp_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      stack_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= stack_mem[mem_raddr];
    end
  end

  assign res_valid = out_valid_r;
  assign res_data  = out_data_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_octave_bound: assert property (@(posedge clk) disable iff (!rst_n)
    oct_r <= OCT_LAST)
    else $error("octave index out of range");

  a_check_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CHK |-> $past(state_r) == S_RDTOP && count_r != '0)
    else $error("top check without a fresh stack read");

  a_idle_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_data_r.tone_active |->
      out_data_r.sounding_key == '0 && out_data_r.half_period_ticks == '0)
    else $error("silent result carries a key or period");

  a_scan_exit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN |=> state_r == S_SCAN || state_r == S_RDTOP)
    else $error("scan left to a wrong state");

endmodule
